// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Screen geometry limits.
	localparam int DEF_MAX_COLS = 80;
	localparam int DEF_MAX_ROWS = 25;

	// Fixed field widths.
	localparam int IDX_W   = 11;
	localparam int COLOR_W = 4;
	localparam int COLS_W  = 7;
	localparam int ROWS_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd3;

	// Register reset values.
	localparam logic [COLOR_W-1:0] RST_FG_COLOR    = 4'd7;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR    = 4'd0;
	localparam logic [COLS_W-1:0]  RST_COLS_IN_USE = 7'd80;
	localparam logic [ROWS_W-1:0]  RST_ROWS_IN_USE = 5'd25;

	// Byte codes that the console interprets.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// One screen cell as stored.
	typedef struct packed {
		logic [7:0]         ch;
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} cell_t;

	localparam cell_t CELL_BLANK = '{ch: CH_SPACE, fg: '0, bg: '0};

	// Command beat.
	typedef struct packed {
		logic             command;
		logic [7:0]       char_byte;
		logic             end_of_write;
		logic [IDX_W-1:0] cell_index;
	} in_item_t;

	// Result beat.
	typedef struct packed {
		logic [IDX_W-1:0]   visible_pos;
		logic [7:0]         cell_char;
		logic [COLOR_W-1:0] cell_fg;
		logic [COLOR_W-1:0] cell_bg;
		logic               in_escape;
	} out_item_t;

	// Configuration registers as seen by the sequencer.
	typedef struct packed {
		logic [COLOR_W-1:0] fg_color;
		logic [COLOR_W-1:0] bg_color;
		logic [COLS_W-1:0]  cols_in_use;
		logic [ROWS_W-1:0]  rows_in_use;
	} cfg_regs_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDATA,
		ST_EXEC,
		ST_PUT,
		ST_SCROLL_SETUP,
		ST_SCROLL,
		ST_FILL,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console engine. A command beat is taken when start is high and busy is low;
// its result beat appears for exactly one cycle with done high, and the receiver
// cannot hold it off. A read command goes from idle to the read data state, which
// registers the result; a write command goes through the execute state, then for a
// printable byte or an erase that clears a cell through the put state that writes
// the cell, and ends in the finish state, which registers the result. A byte that
// moves the cursor past the bottom row scrolls the screen through the memory's read
// port and write port, one cell per cycle. After reset the block clears the screen
// memory, one cell per cycle, and holds busy high meanwhile. Configuration writes
// are always ready and must be issued only while the block is idle.
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire in_item_t              req,
	output logic                       done,
	output out_item_t                  rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	cfg_regs_t     cfg_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	cell_t         mem_rdata;

	assign cfg_ready = 1'b1;

	// Configuration registers, written one beat at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color    <= RST_FG_COLOR;
			cfg_q.bg_color    <= RST_BG_COLOR;
			cfg_q.cols_in_use <= RST_COLS_IN_USE;
			cfg_q.rows_in_use <= RST_ROWS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FG_COLOR:    cfg_q.fg_color    <= cfg_data[COLOR_W-1:0];
				REG_BG_COLOR:    cfg_q.bg_color    <= cfg_data[COLOR_W-1:0];
				REG_COLS_IN_USE: cfg_q.cols_in_use <= cfg_data[COLS_W-1:0];
				REG_ROWS_IN_USE: cfg_q.rows_in_use <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tcw_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.CELLS    (CELLS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg       (cfg_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcw_screen_ram #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_screen_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== hdl/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire cell_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output cell_t              rdata
);

	cell_t mem [DEPTH];
	cell_t rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int CELLS    = MAX_COLS * MAX_ROWS,
	parameter int AW       = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire in_item_t      req,
	output logic               done,
	output out_item_t          rsp,
	input  wire cfg_regs_t     cfg,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output cell_t              mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  wire cell_t         mem_rdata
);

	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ECW = $clog2(MAX_COLS + 1);
	localparam int ERW = $clog2(MAX_ROWS + 1);
	localparam int NW  = $clog2(CELLS + 1);

	// Control registers.
	state_t            state_q, state_d;
	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [RW-1:0]     saved_row_q, saved_row_d;
	logic [CW-1:0]     saved_col_q, saved_col_d;
	logic              esc_q, esc_d;
	logic [IDX_W-1:0]  visible_q, visible_d;
	logic              done_q, done_d;
	logic [NW-1:0]     wr_q, wr_d;
	logic [NW-1:0]     rd_q, rd_d;
	logic [NW-1:0]     end_q, end_d;
	logic              rvalid_s1, rvalid_d;

	// Payload registers.
	logic [7:0]        byte_q, byte_d;
	logic              eow_q, eow_d;
	logic              in_range_q, in_range_d;
	logic [AW-1:0]     addr_q, addr_d;
	logic [7:0]        put_char_q, put_char_d;
	logic              advance_q, advance_d;
	out_item_t         rsp_q, rsp_d;

	// Geometry and position arithmetic.
	logic [ECW-1:0]    eff_cols;
	logic [ERW-1:0]    eff_rows;
	logic [NW-1:0]     mul_a;
	logic [NW-1:0]     prod;
	logic [NW-1:0]     pos_sum;
	logic              col_last;
	logic              row_last;
	logic              can_back;
	logic [RW-1:0]     back_row;
	logic [CW-1:0]     back_col;
	logic              accept;

	function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] c,
			input logic [ECW-1:0] ec);
		logic [CW-1:0] r;
		r = c;
		if (32'(c) >= 32'(ec)) begin
			r = CW'(ec - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [RW-1:0] clamp_row(input logic [RW-1:0] rr,
			input logic [ERW-1:0] er);
		logic [RW-1:0] r;
		r = rr;
		if (32'(rr) >= 32'(er)) begin
			r = RW'(er - 1'b1);
		end
		return r;
	endfunction

	// Effective geometry, limited to the store's shape.
	always_comb begin
		if (cfg.cols_in_use == '0) begin
			eff_cols = ECW'(1);
		end else if (32'(cfg.cols_in_use) > MAX_COLS) begin
			eff_cols = ECW'(MAX_COLS);
		end else begin
			eff_cols = ECW'(cfg.cols_in_use);
		end
		if (cfg.rows_in_use == '0) begin
			eff_rows = ERW'(1);
		end else if (32'(cfg.rows_in_use) > MAX_ROWS) begin
			eff_rows = ERW'(MAX_ROWS);
		end else begin
			eff_rows = ERW'(cfg.rows_in_use);
		end
	end

	// The one multiplier: cursor row times columns, or rows times columns for a scroll.
	assign mul_a   = (state_q == ST_SCROLL_SETUP) ? NW'(eff_rows) : NW'(row_q);
	assign prod    = mul_a * NW'(eff_cols);
	assign pos_sum = prod + NW'(col_q);

	assign col_last = (32'(col_q) + 1) >= 32'(eff_cols);
	assign row_last = (32'(row_q) + 1) >= 32'(eff_rows);

	// One step back, wrapping to the end of the previous row.
	always_comb begin
		can_back = 1'b1;
		back_row = row_q;
		back_col = col_q;
		if (col_q != '0) begin
			back_col = col_q - 1'b1;
		end else if (row_q != '0) begin
			back_row = row_q - 1'b1;
			back_col = CW'(eff_cols - 1'b1);
		end else begin
			can_back = 1'b0;
		end
	end

	assign accept = start && (state_q == ST_IDLE);

	// Next state, datapath updates and memory port control.
	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		saved_row_d = saved_row_q;
		saved_col_d = saved_col_q;
		esc_d       = esc_q;
		visible_d   = visible_q;
		done_d      = 1'b0;
		wr_d        = wr_q;
		rd_d        = rd_q;
		end_d       = end_q;
		rvalid_d    = 1'b0;
		byte_d      = byte_q;
		eow_d       = eow_q;
		in_range_d  = in_range_q;
		addr_d      = addr_q;
		put_char_d  = put_char_q;
		advance_d   = advance_q;
		rsp_d       = rsp_q;
		mem_we      = 1'b0;
		mem_waddr   = wr_q[AW-1:0];
		mem_wdata   = CELL_BLANK;
		mem_re      = 1'b0;
		mem_raddr   = rd_q[AW-1:0];

		case (state_q)
			// Clearing pass over the whole store after reset.
			ST_CLEAR: begin
				mem_we = 1'b1;
				wr_d   = wr_q + 1'b1;
				if (32'(wr_q) == CELLS - 1) begin
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (accept) begin
					byte_d     = req.char_byte;
					eow_d      = req.end_of_write;
					in_range_d = 32'(req.cell_index) < CELLS;
					if (req.command == CMD_READ) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(req.cell_index);
						state_d   = ST_RDATA;
					end else begin
						row_d   = clamp_row(row_q, eff_rows);
						col_d   = clamp_col(col_q, eff_cols);
						state_d = ST_EXEC;
					end
				end
			end

			// Cell data has arrived from the store.
			ST_RDATA: begin
				rsp_d.visible_pos = visible_q;
				rsp_d.in_escape   = esc_q;
				if (in_range_q) begin
					rsp_d.cell_char = mem_rdata.ch;
					rsp_d.cell_fg   = mem_rdata.fg;
					rsp_d.cell_bg   = mem_rdata.bg;
				end else begin
					rsp_d.cell_char = '0;
					rsp_d.cell_fg   = '0;
					rsp_d.cell_bg   = '0;
				end
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end

			// Interpret the byte with the cursor already clamped.
			ST_EXEC: begin
				state_d = ST_FINISH;
				if (esc_q) begin
					esc_d = 1'b0;
					if (byte_q == CH_SEVEN) begin
						saved_row_d = row_q;
						saved_col_d = col_q;
					end else if (byte_q == CH_EIGHT) begin
						row_d = clamp_row(saved_row_q, eff_rows);
						col_d = clamp_col(saved_col_q, eff_cols);
					end
				end else if (byte_q == CH_ESC) begin
					esc_d = 1'b1;
				end else if (byte_q == CH_DEL) begin
					// Erase backward: the erased cell sits one position before the cursor.
					if (can_back) begin
						row_d      = back_row;
						col_d      = back_col;
						addr_d     = AW'(pos_sum - 1'b1);
						put_char_d = CH_SPACE;
						advance_d  = 1'b0;
						state_d    = ST_PUT;
					end
				end else if (byte_q == CH_BS) begin
					row_d = back_row;
					col_d = back_col;
				end else if (byte_q == CH_CR) begin
					col_d = '0;
				end else if (byte_q == CH_LF) begin
					col_d = '0;
					if (row_last) begin
						state_d = ST_SCROLL_SETUP;
					end else begin
						row_d = row_q + 1'b1;
					end
				end else if (byte_q >= CH_SPACE && byte_q <= CH_TILDE) begin
					addr_d     = AW'(pos_sum);
					put_char_d = byte_q;
					advance_d  = 1'b1;
					state_d    = ST_PUT;
				end
			end

			// Write one cell, then advance the cursor for a printable byte.
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = '{ch: put_char_q, fg: cfg.fg_color, bg: cfg.bg_color};
				state_d   = ST_FINISH;
				if (advance_q) begin
					if (col_last) begin
						col_d = '0;
						if (row_last) begin
							state_d = ST_SCROLL_SETUP;
						end else begin
							row_d = row_q + 1'b1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end

			ST_SCROLL_SETUP: begin
				end_d   = prod;
				rd_d    = NW'(eff_cols);
				wr_d    = '0;
				state_d = ST_SCROLL;
			end

			// Move each cell up one row; each cell is written in the cycle after it is read.
			ST_SCROLL: begin
				if (rd_q < end_q) begin
					mem_re   = 1'b1;
					rd_d     = rd_q + 1'b1;
					rvalid_d = 1'b1;
				end
				if (rvalid_s1) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					wr_d      = wr_q + 1'b1;
				end
				if (!(rd_q < end_q) && !rvalid_s1) begin
					state_d = ST_FILL;
				end
			end

			// Blank the bottom row with the current colors.
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = '{ch: CH_SPACE, fg: cfg.fg_color, bg: cfg.bg_color};
				wr_d      = wr_q + 1'b1;
				if ((wr_q + 1'b1) >= end_q) begin
					state_d = ST_FINISH;
				end
			end

			ST_FINISH: begin
				if (eow_q) begin
					visible_d = IDX_W'(pos_sum);
				end
				rsp_d.visible_pos = eow_q ? IDX_W'(pos_sum) : visible_q;
				rsp_d.cell_char   = '0;
				rsp_d.cell_fg     = '0;
				rsp_d.cell_bg     = '0;
				rsp_d.in_escape   = esc_q;
				done_d            = 1'b1;
				state_d           = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and cursor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			row_q       <= '0;
			col_q       <= '0;
			saved_row_q <= '0;
			saved_col_q <= '0;
			esc_q       <= 1'b0;
			visible_q   <= '0;
			done_q      <= 1'b0;
			wr_q        <= '0;
			rd_q        <= '0;
			end_q       <= '0;
			rvalid_s1   <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_q       <= row_d;
			col_q       <= col_d;
			saved_row_q <= saved_row_d;
			saved_col_q <= saved_col_d;
			esc_q       <= esc_d;
			visible_q   <= visible_d;
			done_q      <= done_d;
			wr_q        <= wr_d;
			rd_q        <= rd_d;
			end_q       <= end_d;
			rvalid_s1   <= rvalid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		byte_q     <= byte_d;
		eow_q      <= eow_d;
		in_range_q <= in_range_d;
		addr_q     <= addr_d;
		put_char_q <= put_char_d;
		advance_q  <= advance_d;
		rsp_q      <= rsp_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// A result strobe follows only the cycle that finishes an item.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_RDATA || $past(state_q) == ST_FINISH))
		else $error("result strobe without a finished item");

	// A result strobe is never held high; it drops again straight away.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// The store is never written while waiting for a command.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("screen store written while idle");

	// During a scroll the read pointer stays ahead of the write pointer.
	a_scroll_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && mem_we) |-> (wr_q < rd_q))
		else $error("scroll write overtook its read");

endmodule

`default_nettype wire

// ===== sim/tb_text_console_writer_core.sv =====
`timescale 1ns / 1ps

import tcw_pkg::*;

// Shadow copy of the console: screen, cursor, escape state and registers.
// Every accepted command beat is run through it and its result beat is queued.
class console_scoreboard;
	localparam int unsigned CELL_COUNT = DEF_MAX_COLS * DEF_MAX_ROWS;

	cell_t screen [CELL_COUNT];
	int unsigned cur_row, cur_col, mark_row, mark_col;
	bit esc_wait;
	logic [IDX_W-1:0] shown_cursor;
	logic [COLOR_W-1:0] fg_reg, bg_reg;
	logic [COLS_W-1:0] cols_reg;
	logic [ROWS_W-1:0] rows_reg;
	out_item_t expected_q [$];
	int unsigned errors, checked, commands, reads, scrolls, reg_writes;

	function new();
		foreach (screen[i]) screen[i] = CELL_BLANK;
		cur_row = 0;
		cur_col = 0;
		mark_row = 0;
		mark_col = 0;
		esc_wait = 1'b0;
		shown_cursor = '0;
		fg_reg = RST_FG_COLOR;
		bg_reg = RST_BG_COLOR;
		cols_reg = RST_COLS_IN_USE;
		rows_reg = RST_ROWS_IN_USE;
		errors = 0;
		checked = 0;
		commands = 0;
		reads = 0;
		scrolls = 0;
		reg_writes = 0;
	endfunction

	// Geometry actually used: register values limited to the store size.
	function int unsigned cols_eff();
		if (cols_reg < 1) return 1;
		if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
		return 32'(cols_reg);
	endfunction

	function int unsigned rows_eff();
		if (rows_reg < 1) return 1;
		if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
		return 32'(rows_reg);
	endfunction

	function void clamp_cursor();
		if (cur_col >= cols_eff()) cur_col = cols_eff() - 1;
		if (cur_row >= rows_eff()) cur_row = rows_eff() - 1;
	endfunction

	// Move every line up by one and blank the bottom line in the current colors.
	function void shift_lines();
		int unsigned cols, rows;
		cols = cols_eff();
		rows = rows_eff();
		scrolls++;
		for (int unsigned i = 0; i + cols < rows * cols; i++)
			screen[i] = screen[i + cols];
		for (int unsigned i = (rows - 1) * cols; i < rows * cols; i++) begin
			screen[i].ch = CH_SPACE;
			screen[i].fg = fg_reg;
			screen[i].bg = bg_reg;
		end
		if (cur_row > 0) cur_row--;
	endfunction

	function void next_line();
		cur_row++;
		if (cur_row >= rows_eff()) shift_lines();
	endfunction

	// Store one character at the cursor and advance, wrapping at the right edge.
	function void place(logic [7:0] ch);
		int unsigned pos;
		pos = cur_row * cols_eff() + cur_col;
		if (pos < CELL_COUNT) begin
			screen[pos].ch = ch;
			screen[pos].fg = fg_reg;
			screen[pos].bg = bg_reg;
		end
		cur_col++;
		if (cur_col >= cols_eff()) begin
			cur_col = 0;
			next_line();
		end
	endfunction

	// One step left, wrapping to the end of the line above; false at the top left.
	function bit move_left();
		if (cur_col > 0) begin
			cur_col--;
			return 1'b1;
		end
		if (cur_row > 0) begin
			cur_row--;
			cur_col = cols_eff() - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function void take_byte(logic [7:0] b);
		clamp_cursor();
		if (esc_wait) begin
			// The byte after ESC ends the sequence whatever it is.
			esc_wait = 1'b0;
			if (b == CH_SEVEN) begin
				mark_row = cur_row;
				mark_col = cur_col;
			end else if (b == CH_EIGHT) begin
				cur_row = mark_row;
				cur_col = mark_col;
				clamp_cursor();
			end
			return;
		end
		if (b == CH_ESC) begin
			esc_wait = 1'b1;
		end else if (b == CH_DEL) begin
			if (move_left()) begin
				place(CH_SPACE);
				void'(move_left());
			end
		end else if (b == CH_BS) begin
			void'(move_left());
		end else if (b == CH_CR) begin
			cur_col = 0;
		end else if (b == CH_LF) begin
			cur_col = 0;
			next_line();
		end else if (b >= CH_SPACE && b <= CH_TILDE) begin
			place(b);
		end
	endfunction

	function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		reg_writes++;
		case (idx)
			REG_FG_COLOR: fg_reg = data[COLOR_W-1:0];
			REG_BG_COLOR: bg_reg = data[COLOR_W-1:0];
			REG_COLS_IN_USE: cols_reg = data[COLS_W-1:0];
			REG_ROWS_IN_USE: rows_reg = data[ROWS_W-1:0];
			default: ;
		endcase
	endfunction

	// Apply one accepted command beat and queue the result beat it must produce.
	function void note_command(in_item_t item);
		out_item_t want;
		want = '0;
		commands++;
		if (item.command == CMD_WRITE) begin
			take_byte(item.char_byte);
			if (item.end_of_write) begin
				clamp_cursor();
				shown_cursor = IDX_W'((cur_row * cols_eff() + cur_col) % (1 << IDX_W));
			end
		end else begin
			reads++;
			if (item.cell_index < CELL_COUNT) begin
				want.cell_char = screen[item.cell_index].ch;
				want.cell_fg = screen[item.cell_index].fg;
				want.cell_bg = screen[item.cell_index].bg;
			end
		end
		want.visible_pos = shown_cursor;
		want.in_escape = esc_wait;
		expected_q.push_back(want);
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result beat with no command outstanding, expected none, actual %h",
				$time, got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		compare_field("visible_pos", 16'(want.visible_pos), 16'(got.visible_pos));
		compare_field("cell_char", 16'(want.cell_char), 16'(got.cell_char));
		compare_field("cell_fg", 16'(want.cell_fg), 16'(got.cell_fg));
		compare_field("cell_bg", 16'(want.cell_bg), 16'(got.cell_bg));
		compare_field("in_escape", 16'(want.in_escape), 16'(got.in_escape));
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction
endclass

module tb_text_console_writer_core;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int PHASES = 16;
	localparam int ITEMS_PER_PHASE = 38;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t req;
	logic done;
	out_item_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	console_scoreboard sb;
	bit no_idle;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	text_console_writer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels at each edge: results first, then new command and register beats.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(rsp);
			if (start && !busy) sb.note_command(req);
			if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, sb.pending());
			$display("tb_text_console_writer_core: errors");
			$finish;
		end
	end

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_item_t write_beat(logic [7:0] b, logic last);
		in_item_t item;
		item.command = CMD_WRITE;
		item.char_byte = b;
		item.end_of_write = last;
		item.cell_index = IDX_W'($urandom_range(0, 2047));
		return item;
	endfunction

	function automatic in_item_t read_beat(int unsigned pos);
		in_item_t item;
		item.command = CMD_READ;
		item.char_byte = 8'($urandom_range(0, 255));
		item.end_of_write = 1'($urandom_range(0, 1));
		item.cell_index = IDX_W'(pos);
		return item;
	endfunction

	// Present one command beat and hold it until the block takes it.
	task automatic drive_item(in_item_t item);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Stop sending and wait until every result is in and the block is idle.
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0 || busy);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Unused upper data bits are filled at random; the block must ignore them.
	task automatic apply_settings(logic [3:0] fg, logic [3:0] bg, logic [6:0] cols,
			logic [4:0] rows);
		wait_idle();
		write_register(REG_FG_COLOR, {3'($urandom_range(0, 7)), fg});
		write_register(REG_BG_COLOR, {3'($urandom_range(0, 7)), bg});
		write_register(REG_COLS_IN_USE, cols);
		write_register(REG_ROWS_IN_USE, {2'($urandom_range(0, 3)), rows});
		cfg_valid <= 1'b0;
	endtask

	// A burst of text with the odd line break, carriage return or backspace, ending on the last byte of a write.
	task automatic send_text_run();
		int unsigned n, r;
		logic [7:0] b;
		n = $urandom_range(1, 12);
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 84) b = 8'($urandom_range(CH_SPACE, CH_TILDE));
			else if (r < 92) b = CH_LF;
			else if (r < 96) b = CH_CR;
			else b = CH_BS;
			drive_item(write_beat(b, (i == n - 1) || ($urandom_range(0, 9) == 0)));
		end
	endtask

	// Random traffic built from short well-formed sequences plus some noise.
	task automatic random_traffic(int unsigned count);
		int unsigned stop, r, n, span;
		logic [7:0] b;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_text_run();
			end else if (r < 55) begin
				// Save or restore, sometimes a dropped escape.
				drive_item(write_beat(CH_ESC, 1'($urandom_range(0, 1))));
				n = $urandom_range(0, 9);
				b = (n < 4) ? CH_SEVEN : (n < 8) ? CH_EIGHT : 8'($urandom_range(0, 255));
				drive_item(write_beat(b, 1'($urandom_range(0, 1))));
			end else if (r < 65) begin
				n = $urandom_range(1, 3);
				repeat (n)
					drive_item(write_beat($urandom_range(0, 1) ? CH_DEL : CH_BS,
						1'($urandom_range(0, 1))));
			end else if (r < 85) begin
				// Reads mostly inside the visible screen, some anywhere in the address range.
				span = sb.cols_eff() * sb.rows_eff();
				n = $urandom_range(1, 4);
				repeat (n)
					drive_item(read_beat(($urandom_range(0, 9) < 8) ?
						$urandom_range(0, span - 1) : $urandom_range(0, 2047)));
			end else begin
				n = $urandom_range(1, 3);
				repeat (n)
					drive_item(write_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FG_COLOR;
		cfg_data = '0;
		no_idle = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its screen store after reset; wait for it.
		wait_idle();

		// Directed: erase at the top left, printable extremes, ignored bytes,
		// save and restore, dropped escapes, and reads at the ends of the store.
		drive_item(write_beat(CH_DEL, 1'b1));
		drive_item(write_beat(CH_BS, 1'b1));
		drive_item(read_beat(0));
		drive_item(write_beat(CH_SPACE, 1'b0));
		drive_item(write_beat(CH_TILDE, 1'b0));
		drive_item(write_beat(8'h41, 1'b1));
		drive_item(write_beat(8'h01, 1'b0));
		drive_item(write_beat(8'h80, 1'b0));
		drive_item(write_beat(8'hFF, 1'b1));
		drive_item(write_beat(CH_ESC, 1'b0));
		drive_item(write_beat(CH_SEVEN, 1'b1));
		drive_item(write_beat(CH_CR, 1'b0));
		drive_item(write_beat(CH_LF, 1'b1));
		drive_item(write_beat(CH_ESC, 1'b0));
		drive_item(write_beat(CH_EIGHT, 1'b1));
		drive_item(write_beat(CH_ESC, 1'b0));
		drive_item(write_beat(CH_ESC, 1'b1));
		drive_item(write_beat(CH_ESC, 1'b0));
		drive_item(write_beat(8'h78, 1'b0));
		drive_item(write_beat(CH_DEL, 1'b1));
		drive_item(read_beat(2));
		drive_item(read_beat(1999));
		drive_item(read_beat(2000));
		drive_item(read_beat(2047));

		// Random phases, each under its own geometry and colors.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_settings(4'd0, 4'd15, 7'd0, 5'd0);
				1: apply_settings(4'd15, 4'd0, 7'd127, 5'd31);
				2: apply_settings(4'd5, 4'd10, 7'd1, 5'd25);
				3: apply_settings(4'd9, 4'd3, 7'd80, 5'd1);
				4: apply_settings(4'd7, 4'd0, 7'd80, 5'd25);
				default: begin
					if ($urandom_range(0, 3) == 0)
						apply_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
							7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
					else
						apply_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
							7'($urandom_range(1, 16)), 5'($urandom_range(1, 8)));
				end
			endcase
			no_idle = (p % 4 == 3);
			random_traffic(ITEMS_PER_PHASE);
			no_idle = 1'b0;
		end

		wait_idle();
		repeat (20) @(posedge clk);

		if (sb.pending() != 0) begin
			$display("%0d expected results never arrived.", sb.pending());
			sb.errors++;
		end
		$display("Sent %0d command beats (%0d cell reads) under %0d register writes.",
			sb.commands, sb.reads, sb.reg_writes);
		$display("Checked %0d result beats; the traffic forced %0d screen scrolls.",
			sb.checked, sb.scrolls);
		if (sb.errors == 0) begin
			$display("tb_text_console_writer_core: clean");
		end else begin
			$display("tb_text_console_writer_core: errors");
		end
		$finish;
	end
endmodule

// ===== text_console_writer_core.f =====
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_ctrl.sv
hdl/text_console_writer_core.sv
sim/tb_text_console_writer_core.sv
